// ----- sv/xcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND   = 8'hBB;
    localparam int unsigned LEN_OVERHEAD  = 5;

    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_CHECKSUM = 2'd1;
    localparam logic [1:0]  ST_HEADER   = 2'd2;
    localparam logic [1:0]  ST_LENGTH   = 2'd3;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = 1;
    localparam int unsigned QCW    = 2;

    typedef struct packed {
        logic        is_frame_end;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic [15:0] frame_command;
        logic [15:0] device_descriptor;
        logic [6:0]  payload_length;
        logic [1:0]  frame_status;
    } t_result;

endpackage

// ----- sv/xcfd_front.sv -----
// ----------------------------------------------------------------------------
// xcfd_front
// Byte parser: tracks the frame position and classifies each byte.
// ----------------------------------------------------------------------------
module xcfd_front
    import xcfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_full,
    input  logic [7:0] i_rx_byte,
    output logic    o_stall,
    output logic    o_push,
    output t_result o_result
);

    localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);

    localparam logic [3:0] S_SYNC1   = 4'd0;
    localparam logic [3:0] S_SYNC2   = 4'd1;
    localparam logic [3:0] S_LEN_LO  = 4'd2;
    localparam logic [3:0] S_LEN_HI  = 4'd3;
    localparam logic [3:0] S_DESC_HI = 4'd4;
    localparam logic [3:0] S_DESC_LO = 4'd5;
    localparam logic [3:0] S_CMD_LO  = 4'd6;
    localparam logic [3:0] S_CMD_HI  = 4'd7;
    localparam logic [3:0] S_PAYLOAD = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [7:0]    r_len_lo, n_len_lo;
    logic [PW-1:0] r_plen, n_plen;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_xor, n_xor;
    logic [15:0]   r_cmd, n_cmd;
    logic [15:0]   r_desc, n_desc;

    logic          w_accept;
    logic [15:0]   w_len;
    logic [15:0]   w_plen16;
    logic [15:0]   w_plen_ext;
    logic [15:0]   w_cnt_ext;

    assign o_stall    = i_full;
    assign w_accept   = i_valid && !i_full;
    assign w_len      = {i_rx_byte, r_len_lo};
    assign w_plen16   = w_len - 16'(LEN_OVERHEAD);
    assign w_plen_ext = 16'(r_plen);
    assign w_cnt_ext  = 16'(r_cnt);

    always_comb begin
        n_state  = r_state;
        n_len_lo = r_len_lo;
        n_plen   = r_plen;
        n_cnt    = r_cnt;
        n_xor    = r_xor;
        n_cmd    = r_cmd;
        n_desc   = r_desc;
        o_push   = 1'b0;
        o_result = '0;
        if (w_accept) begin
            unique case (r_state)
                S_SYNC1: begin
                    if (i_rx_byte == SYNC_FIRST) begin
                        n_state = S_SYNC2;
                    end else begin
                        o_push                = 1'b1;
                        o_result.is_frame_end = 1'b1;
                        o_result.frame_status = ST_HEADER;
                    end
                end
                S_SYNC2: begin
                    if (i_rx_byte == SYNC_SECOND) begin
                        n_state = S_LEN_LO;
                    end else begin
                        n_state               = S_SYNC1;
                        o_push                = 1'b1;
                        o_result.is_frame_end = 1'b1;
                        o_result.frame_status = ST_HEADER;
                    end
                end
                S_LEN_LO: begin
                    n_len_lo = i_rx_byte;
                    n_state  = S_LEN_HI;
                end
                S_LEN_HI: begin
                    if (w_len < 16'(LEN_OVERHEAD) ||
                        w_len > 16'(MAX_PAYLOAD + LEN_OVERHEAD)) begin
                        n_state               = S_SYNC1;
                        o_push                = 1'b1;
                        o_result.is_frame_end = 1'b1;
                        o_result.frame_status = ST_LENGTH;
                    end else begin
                        n_plen  = w_plen16[PW-1:0];
                        n_cnt   = '0;
                        n_xor   = '0;
                        n_state = S_DESC_HI;
                    end
                end
                S_DESC_HI: begin
                    n_xor   = r_xor ^ i_rx_byte;
                    n_desc  = {i_rx_byte, 8'h00};
                    n_state = S_DESC_LO;
                end
                S_DESC_LO: begin
                    n_xor   = r_xor ^ i_rx_byte;
                    n_desc  = {r_desc[15:8], i_rx_byte};
                    n_state = S_CMD_LO;
                end
                S_CMD_LO: begin
                    n_xor   = r_xor ^ i_rx_byte;
                    n_cmd   = {8'h00, i_rx_byte};
                    n_state = S_CMD_HI;
                end
                S_CMD_HI: begin
                    n_xor   = r_xor ^ i_rx_byte;
                    n_cmd   = {i_rx_byte, r_cmd[7:0]};
                    n_state = S_PAYLOAD;
                end
                S_PAYLOAD: begin
                    o_push = 1'b1;
                    if (r_cnt < r_plen) begin
                        n_xor                  = r_xor ^ i_rx_byte;
                        n_cnt                  = r_cnt + 1'b1;
                        o_result.payload_byte  = i_rx_byte;
                        o_result.payload_index = w_cnt_ext[5:0];
                    end else begin
                        n_state                    = S_SYNC1;
                        o_result.is_frame_end      = 1'b1;
                        o_result.frame_command     = r_cmd;
                        o_result.device_descriptor = r_desc;
                        o_result.payload_length    = w_plen_ext[6:0];
                        o_result.frame_status      = (i_rx_byte == r_xor) ? ST_OK
                                                                          : ST_CHECKSUM;
                    end
                end
                default: begin
                    n_state = S_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC1;
            r_cnt   <= '0;
            r_plen  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_plen  <= n_plen;
        end
        r_len_lo <= n_len_lo;
        r_xor    <= n_xor;
        r_cmd    <= n_cmd;
        r_desc   <= n_desc;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAYLOAD |-> r_cnt <= r_plen)
        else $error("payload count beyond length");

    a_push_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_accept)
        else $error("push without accepted byte");

    a_len_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.frame_status == ST_LENGTH |=> r_state == S_SYNC1)
        else $error("parser not back at start after length error");

endmodule

// ----- sv/xcfd_queue.sv -----
// ----------------------------------------------------------------------------
// xcfd_queue
// Two-entry request queue between parser and output stage.
// ----------------------------------------------------------------------------
module xcfd_queue
    import xcfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_nempty,
    output t_result o_data
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;

    assign o_full   = (r_cnt == QCW'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/xcfd_back.sv -----
// ----------------------------------------------------------------------------
// xcfd_back
// Output register: drains the queue and presents one result at a time.
// ----------------------------------------------------------------------------
module xcfd_back
    import xcfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_nempty,
    input  t_result i_data,
    input  logic    i_stall,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_pop    = i_nempty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped request not presented");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !o_pop)
        else $error("pop while output held");

    a_drop_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_stall && !i_nempty |=> !r_valid)
        else $error("taken result not dropped");

endmodule

// ----- sv/xor_checked_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_unit
// Sync/length/XOR-checksum frame parser with payload and summary results.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | i_valid / o_stall  | i_rx_byte
//   output  | out       | o_valid / i_stall  | o_is_frame_end .. o_frame_status
//
// One byte is accepted per cycle while o_stall is low; the parser state is registered.
// Results pass a two-entry queue and an output register.
// o_stall rises only when the queue is full, i.e. after the output has stalled.
// Reset is synchronous and active low; the parser returns to the first sync byte.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer_unit
    import xcfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_frame_end,
    output logic [7:0]  o_payload_byte,
    output logic [5:0]  o_payload_index,
    output logic [15:0] o_frame_command,
    output logic [15:0] o_device_descriptor,
    output logic [6:0]  o_payload_length,
    output logic [1:0]  o_frame_status
);

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_nempty;
    t_result w_front_res;
    t_result w_queue_res;
    t_result w_out_res;

    xcfd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_full    (w_full),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .o_push    (w_push),
        .o_result  (w_front_res)
    );

    xcfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_front_res),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_data   (w_queue_res)
    );

    xcfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nempty (w_nempty),
        .i_data   (w_queue_res),
        .i_stall  (i_stall),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_result (w_out_res)
    );

    assign o_is_frame_end      = w_out_res.is_frame_end;
    assign o_payload_byte      = w_out_res.payload_byte;
    assign o_payload_index     = w_out_res.payload_index;
    assign o_frame_command     = w_out_res.frame_command;
    assign o_device_descriptor = w_out_res.device_descriptor;
    assign o_payload_length    = w_out_res.payload_length;
    assign o_frame_status      = w_out_res.frame_status;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of the sync/length/XOR-checksum frame deframer.
// A queue of received bytes feeds a valid/stall driver. Each accepted byte
// goes through a local frame parser, which yields the payload or summary
// result that the unit should return. A monitor checks every returned result
// against the oldest predicted one. The stimulus starts with short directed
// cases and then runs random traffic. That traffic is mostly well-formed
// frames, with noise bytes, broken headers, bad lengths and truncated frames
// mixed in. Idling changes from phase to phase, and the run includes one long
// output hold-off and one sender pause that waits until all results are back.
// ----------------------------------------------------------------------------
module testbench;
    import xcfd_pkg::*;

    typedef struct {
        logic [7:0] rx_byte;
        bit         drain_first;
    } t_rx_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_is_frame_end;
    logic [7:0]  o_payload_byte;
    logic [5:0]  o_payload_index;
    logic [15:0] o_frame_command;
    logic [15:0] o_device_descriptor;
    logic [6:0]  o_payload_length;
    logic [1:0]  o_frame_status;

    t_rx_req     rx_queue[$];
    t_result     parsed_results[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold_left = 0;
    int          bytes_queued = 0;
    bit          drain_next = 1'b0;

    int unsigned frm_pos = 0;
    logic [15:0] frm_len = '0;
    logic [7:0]  frm_xor = '0;
    logic [15:0] frm_cmd = '0;
    logic [15:0] frm_desc = '0;

    xor_checked_frame_deframer_unit #(.MAX_PAYLOAD(64)) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_is_frame_end      (o_is_frame_end),
        .o_payload_byte      (o_payload_byte),
        .o_payload_index     (o_payload_index),
        .o_frame_command     (o_frame_command),
        .o_device_descriptor (o_device_descriptor),
        .o_payload_length    (o_payload_length),
        .o_frame_status      (o_frame_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void restart_frame();
        frm_pos  = 0;
        frm_len  = '0;
        frm_xor  = '0;
        frm_cmd  = '0;
        frm_desc = '0;
    endfunction

    function automatic bit parse_rx_byte(input logic [7:0] b, output t_result r);
        int unsigned plen;
        bit          hit;
        r = '0;
        r.is_frame_end = 1'b1;
        hit = 1'b0;
        if (frm_pos == 0) begin
            if (b != SYNC_FIRST) begin
                r.frame_status = ST_HEADER;
                hit = 1'b1;
            end else begin
                frm_pos = 1;
            end
        end else if (frm_pos == 1) begin
            if (b != SYNC_SECOND) begin
                restart_frame();
                r.frame_status = ST_HEADER;
                hit = 1'b1;
            end else begin
                frm_pos = 2;
            end
        end else if (frm_pos == 2) begin
            frm_len = {8'h00, b};
            frm_pos = 3;
        end else if (frm_pos == 3) begin
            frm_len[15:8] = b;
            if (frm_len < LEN_OVERHEAD || frm_len - LEN_OVERHEAD > 64) begin
                restart_frame();
                r.frame_status = ST_LENGTH;
                hit = 1'b1;
            end else begin
                frm_pos = 4;
            end
        end else if (frm_pos < 8) begin
            frm_xor ^= b;
            case (frm_pos)
                4: frm_desc[15:8] = b;
                5: frm_desc[7:0] = b;
                6: frm_cmd[7:0] = b;
                default: frm_cmd[15:8] = b;
            endcase
            frm_pos++;
        end else begin
            plen = frm_len - LEN_OVERHEAD;
            hit = 1'b1;
            if (frm_pos - 8 < plen) begin
                frm_xor ^= b;
                r.is_frame_end = 1'b0;
                r.payload_byte = b;
                r.payload_index = 6'(frm_pos - 8);
                frm_pos++;
            end else begin
                r.frame_command = frm_cmd;
                r.device_descriptor = frm_desc;
                r.payload_length = 7'(plen);
                r.frame_status = (b == frm_xor) ? ST_OK : ST_CHECKSUM;
                restart_frame();
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_rx_req req;
        req.rx_byte = b;
        req.drain_first = drain_next;
        drain_next = 1'b0;
        rx_queue.push_back(req);
        bytes_queued++;
    endtask

    // keep < 0 sends the whole frame, otherwise only its first keep bytes
    task automatic push_frame(input int plen, input logic [15:0] desc,
                              input logic [15:0] cmd, input bit corrupt,
                              input int keep);
        logic [7:0]  fb[$];
        logic [7:0]  x;
        logic [15:0] len;
        len = 16'(plen + LEN_OVERHEAD);
        fb.push_back(SYNC_FIRST);
        fb.push_back(SYNC_SECOND);
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        fb.push_back(desc[15:8]);
        fb.push_back(desc[7:0]);
        fb.push_back(cmd[7:0]);
        fb.push_back(cmd[15:8]);
        x = desc[15:8] ^ desc[7:0] ^ cmd[7:0] ^ cmd[15:8];
        for (int i = 0; i < plen; i++) begin
            fb.push_back(8'($urandom_range(0, 255)));
            x ^= fb[$];
        end
        if (corrupt)
            x ^= 8'(1 << $urandom_range(0, 7));
        fb.push_back(x);
        for (int i = 0; i < fb.size() && (keep < 0 || i < keep); i++)
            push_byte(fb[i]);
    endtask

    task automatic gen_traffic(input int target);
        int          start;
        int          pick;
        int          plen;
        logic [15:0] len;
        logic [7:0]  b;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) :
                                                  $urandom_range(13, 64);
            if (pick < 70) begin
                push_frame(plen, 16'($urandom), 16'($urandom),
                           $urandom_range(0, 99) < 15, -1);
            end else if (pick < 80) begin
                push_byte(8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
                b = 8'($urandom_range(0, 255));
                if (b == SYNC_SECOND)
                    b = SYNC_FIRST;
                push_byte(SYNC_FIRST);
                push_byte(b);
            end else if (pick < 96) begin
                len = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) :
                                             16'($urandom_range(70, 65535));
                push_byte(SYNC_FIRST);
                push_byte(SYNC_SECOND);
                push_byte(len[7:0]);
                push_byte(len[15:8]);
            end else begin
                push_frame(plen, 16'($urandom), 16'($urandom), 1'b0,
                           $urandom_range(2, plen + 8));
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_queue.size() != 0 || i_valid || parsed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // predict on each accepted request, then pick the next one
    always @(posedge i_clk) begin : drive_rx
        t_result r;
        bit      offer;
        t_rx_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (parse_rx_byte(i_rx_byte, r))
                    parsed_results.push_back(r);
            end
            if (!i_valid || !o_stall) begin
                offer = 1'b0;
                if (rx_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    if (!rx_queue[0].drain_first || parsed_results.size() == 0)
                        offer = 1'b1;
                end
                if (offer) begin
                    nxt = rx_queue.pop_front();
                    i_rx_byte <= nxt.rx_byte;
                end
                i_valid <= offer;
            end
        end
    end

    always @(posedge i_clk) begin
        if (recv_hold_left != 0) begin
            i_stall <= 1'b1;
            recv_hold_left <= recv_hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result exp_r;
        string   bad;
        if (i_rst_n && o_valid && !i_stall) begin
            if (parsed_results.size() == 0) begin
                report_mismatch("result returned with none predicted");
            end else begin
                exp_r = parsed_results.pop_front();
                bad = "";
                if (o_is_frame_end !== exp_r.is_frame_end)
                    bad = {bad, " is_frame_end"};
                if (o_payload_byte !== exp_r.payload_byte)
                    bad = {bad, " payload_byte"};
                if (o_payload_index !== exp_r.payload_index)
                    bad = {bad, " payload_index"};
                if (o_frame_command !== exp_r.frame_command)
                    bad = {bad, " frame_command"};
                if (o_device_descriptor !== exp_r.device_descriptor)
                    bad = {bad, " device_descriptor"};
                if (o_payload_length !== exp_r.payload_length)
                    bad = {bad, " payload_length"};
                if (o_frame_status !== exp_r.frame_status)
                    bad = {bad, " frame_status"};
                if (bad != "")
                    report_mismatch($sformatf("wrong%s, expected %h", bad, exp_r));
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 55;
        push_byte(8'h00);
        push_byte(SYNC_FIRST);
        push_byte(8'hFF);
        push_frame(0, 16'h0000, 16'h0000, 1'b0, 4);
        push_frame(-1, 16'h0000, 16'h0000, 1'b0, 4);
        push_frame(65, 16'h0000, 16'h0000, 1'b0, 4);
        push_frame(0, 16'h0000, 16'h0000, 1'b0, -1);
        push_frame(64, 16'hFFFF, 16'hFFFF, 1'b0, -1);
        push_frame(1, 16'hA55A, 16'h8001, 1'b1, -1);
        gen_traffic(480);
        wait_drained();

        send_idle_pct = 55;
        recv_idle_pct = 25;
        gen_traffic(280);
        drain_next = 1'b1;
        gen_traffic(280);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_traffic(560);
        @(negedge i_clk);
        recv_hold_left = 300;
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (parsed_results.size() != 0)
            report_mismatch("predicted results never returned");
        if (mismatches == 0)
            $display("xor_checked_frame_deframer_unit: match");
        else
            $display("xor_checked_frame_deframer_unit: mismatch");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("xor_checked_frame_deframer_unit: mismatch");
        $finish;
    end

endmodule
